// File: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the store geometry, operation and status codes, and the
// memory request and stage structs used by the controller, RAM and top level.
`default_nettype none

package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int VAL_W  = 32;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int FILL_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_REAR  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		logic             pop_ok;
		logic [CNT_W-1:0] count;
	} stage_t;

endpackage

`default_nettype wire

// File: rtl/dq_ram.sv
// Entry store of the double-ended queue: one write and one read port,
// read data registered. Depends on dq_pkg.
`default_nettype none

module dq_ram
	import dq_pkg::*;
(
	input  wire logic             clk,
	input  wire mem_req_t         req,
	output logic      [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		// hold read data while no new read is issued
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/dq_ctrl.sv
// Pointer and count control of the double-ended queue: decodes an operation,
// moves head or tail, issues the RAM access and holds the beat in stage 1.
// Depends on dq_pkg.
`default_nettype none

module dq_ctrl
	import dq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OP_W-1:0]  in_op,
	input  wire logic [VAL_W-1:0] in_value,
	output mem_req_t              mem_req,
	output logic                  s1_valid,
	output stage_t                s1_info,
	input  wire logic             s1_advance
);

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             s1_valid_q;
	stage_t           s1_q, stage_d;
	logic             acc, full, empty;
	op_t              op;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

	assign in_ready = !s1_valid_q;
	assign acc      = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign op       = op_t'(in_op);

	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		mem_req        = '0;
		mem_req.wdata  = in_value;
		stage_d.status = ST_OK;
		stage_d.pop_ok = 1'b0;
		if (acc) begin
			case (op)
				OP_PUSH_FRONT: begin
					if (full) begin
						stage_d.status = ST_FULL;
					end else begin
						head_d        = wrap_dec(head_q);
						mem_req.we    = 1'b1;
						mem_req.waddr = head_d;
						count_d       = count_q + CNT_W'(1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						stage_d.status = ST_EMPTY;
					end else begin
						mem_req.re     = 1'b1;
						mem_req.raddr  = head_q;
						head_d         = wrap_inc(head_q);
						count_d        = count_q - CNT_W'(1);
						stage_d.pop_ok = 1'b1;
					end
				end
				OP_PUSH_REAR: begin
					if (full) begin
						stage_d.status = ST_FULL;
					end else begin
						tail_d        = wrap_inc(tail_q);
						mem_req.we    = 1'b1;
						mem_req.waddr = tail_d;
						count_d       = count_q + CNT_W'(1);
					end
				end
				default: begin
					if (empty) begin
						stage_d.status = ST_EMPTY;
					end else begin
						mem_req.re     = 1'b1;
						mem_req.raddr  = tail_q;
						tail_d         = wrap_dec(tail_q);
						count_d        = count_q - CNT_W'(1);
						stage_d.pop_ok = 1'b1;
					end
				end
			endcase
		end
		stage_d.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= IDX_W'(DEPTH - 1);
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_q <= stage_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_info  = s1_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
		|=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("push on full queue changed state");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not add one entry");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !empty && (op == OP_POP_FRONT || op == OP_POP_REAR)
		|-> mem_req.re && !mem_req.we)
		else $error("pop issued no read");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_q.pop_ok |-> s1_q.status == ST_OK)
		else $error("successful pop with error status");

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values, DEPTH entries in one RAM.
//
// Input beat (s_*): tuser carries the operation (push front, pop front,
// push rear, pop rear), tdata the value to push (ignored by pops).
// Output beat (m_*): tuser carries the status (ok, empty, full), tdata the
// popped value (zero unless a pop succeeded) and the fill count after the
// operation. Every input beat gives exactly one output beat, in order.
//
// Flow: an accepted beat is held in stage 1, then loaded into the output
// register that drives m_tvalid. The entry RAM is read at the accepting edge
// and the output register loads when stage 1 advances; while stage 1 holds a
// beat s_tready is low, so a new beat is taken only after the last one has
// moved on to the output register.
// While a result waits in the output register, one more beat is accepted and
// held in stage 1; s_tready then drops until m_tready takes the waiting beat.
// Reset (arst_n low) empties the queue: head at entry zero, tail one before
// it, count zero. RAM contents are not cleared and need no clearing pass.
// Depends on dq_pkg, dq_ctrl, dq_ram.
`default_nettype none

module double_ended_queue
	import dq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] value
	input  wire logic [1:0]  s_tuser,  // [1:0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // [31:0] popped_value, [36:32] fill_count, rest zero
	output logic      [1:0]  m_tuser   // [1:0] status
);

	mem_req_t         mem_req;
	logic [VAL_W-1:0] rdata;
	logic             s1_valid, s1_advance;
	stage_t           s1_info;

	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [FILL_W-1:0] out_fill_q;

	dq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_value   (s_tdata),
		.mem_req    (mem_req),
		.s1_valid   (s1_valid),
		.s1_info    (s1_info),
		.s1_advance (s1_advance)
	);

	dq_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// advance stage 1 when the output register is free or being drained
	assign s1_advance = s1_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			out_status_q <= s1_info.status;
			out_value_q  <= s1_info.pop_ok ? rdata : '0;
			out_fill_q   <= FILL_W'(s1_info.count);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_fill_q, out_value_q};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the double_ended_queue stream block.
// Drives operation beats, predicts each result from its own copy of the deque
// and checks every output beat in order. Depends on dq_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top;
	import dq_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   popped;
		logic [FILL_W-1:0]  fill;
	} result_t;

	typedef struct {
		op_t              op;
		logic [VAL_W-1:0] value;
		bit               typed;
		result_t          want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] value
	logic [1:0]  s_tuser;  // [1:0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // [31:0] popped_value, [36:32] fill_count, rest zero
	logic [1:0]  m_tuser;  // [1:0] status

	double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Shadow copy of the deque
	logic [VAL_W-1:0] slot_mem [DEPTH];
	logic [IDX_W-1:0] front_idx = '0;
	logic [IDX_W-1:0] rear_idx  = '1;
	logic [CNT_W-1:0] occupancy = '0;

	result_t pending_results [$];
	row_t    dir_rows [$];

	int  mismatches    = 0;
	int  beats_sent    = 0;
	int  beats_checked = 0;
	int  full_seen     = 0;
	int  empty_seen    = 0;
	int  pops_ok_seen  = 0;
	bit  send_quiet    = 1'b0;
	bit  recv_quiet    = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic result_t deque_apply(op_t op, logic [VAL_W-1:0] v);
		result_t r;
		r.status = ST_OK;
		r.popped = '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					front_idx = front_idx - 1'b1;
					slot_mem[front_idx] = v;
					occupancy++;
				end
			end
			OP_POP_FRONT: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = slot_mem[front_idx];
					front_idx = front_idx + 1'b1;
					occupancy--;
				end
			end
			OP_PUSH_REAR: begin
				if (occupancy >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					rear_idx = rear_idx + 1'b1;
					slot_mem[rear_idx] = v;
					occupancy++;
				end
			end
			default: begin
				if (occupancy == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = slot_mem[rear_idx];
					rear_idx = rear_idx - 1'b1;
					occupancy--;
				end
			end
		endcase
		r.fill = occupancy[FILL_W-1:0];
		return r;
	endfunction

	function automatic row_t make_row(op_t op, logic [VAL_W-1:0] v, bit typed,
			status_t st, logic [VAL_W-1:0] pop, int fill);
		row_t r;
		r.op          = op;
		r.value       = v;
		r.typed       = typed;
		r.want.status = st;
		r.want.popped = pop;
		r.want.fill   = fill[FILL_W-1:0];
		return r;
	endfunction

	// Mostly zero, some short, a few long
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Drive one beat, hold it until accepted, then record its expected result
	task automatic send_beat(row_t row);
		int      gap;
		result_t predicted;
		gap = pick_gap(send_quiet);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = row.op;
		s_tdata  = row.value;
		do @(posedge clk); while (!s_tready);
		predicted = deque_apply(row.op, row.value);
		pending_results.push_back(row.typed ? row.want : predicted);
		beats_sent++;
	endtask

	task automatic note_failure(string what, result_t want, result_t got);
		if (mismatches < MAX_REPORTS)
			$display("%0t: %s: want st=%0d pop=%h fill=%0d, got st=%0d pop=%h fill=%0d",
				$realtime, what, want.status, want.popped, want.fill,
				got.status, got.popped, got.fill);
		mismatches++;
	endtask

	// Output checker
	result_t got_beat;
	result_t want_beat;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat.status = status_t'(m_tuser);
			got_beat.popped = m_tdata[31:0];
			got_beat.fill   = m_tdata[36:32];
			if (pending_results.size() == 0) begin
				want_beat = '0;
				note_failure("unexpected beat", want_beat, got_beat);
			end else begin
				want_beat = pending_results.pop_front();
				beats_checked++;
				if (want_beat.status == ST_FULL)
					full_seen++;
				if (want_beat.status == ST_EMPTY)
					empty_seen++;
				if (want_beat.status == ST_OK && got_beat.popped != 0)
					pops_ok_seen++;
				if (got_beat.status !== want_beat.status ||
						got_beat.popped !== want_beat.popped ||
						got_beat.fill !== want_beat.fill)
					note_failure("mismatch", want_beat, got_beat);
			end
		end
	end

	// Receiver: random stalls, with stretches of none
	initial begin
		int stall_left;
		int stretch;
		stall_left = 0;
		stretch    = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch    = $urandom_range(20, 200);
				recv_quiet = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else begin
				stall_left = pick_gap(recv_quiet);
				m_tready   = (stall_left == 0);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int   mode_left;
		int   mode;
		int   r;
		row_t row;
		op_t  op;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;

		// op, value, typed, status, popped, fill
		dir_rows.push_back(make_row(OP_POP_FRONT,  32'hA5A5_A5A5, 1, ST_EMPTY, 32'h0, 0));
		dir_rows.push_back(make_row(OP_POP_REAR,   32'h5A5A_5A5A, 1, ST_EMPTY, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1, ST_OK, 32'h0, 1));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'h8000_0000, 1, ST_OK, 32'h0, 2));
		dir_rows.push_back(make_row(OP_POP_FRONT,  32'hFFFF_FFFF, 1, ST_OK, 32'h7FFF_FFFF, 1));
		dir_rows.push_back(make_row(OP_POP_REAR,   32'h0000_0000, 1, ST_OK, 32'h8000_0000, 0));
		// last element leaves from the other end
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hFFFF_FFFF, 1, ST_OK, 32'h0, 1));
		dir_rows.push_back(make_row(OP_POP_FRONT,  32'h1234_5678, 1, ST_OK, 32'hFFFF_FFFF, 0));
		// fill to capacity from both ends
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h0000_0001, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hFFFF_FFFE, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h5555_5555, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hAAAA_AAAA, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h8000_0000, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'h7FFF_FFFF, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h0F0F_0F0F, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hF0F0_F0F0, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h00FF_00FF, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hFF00_FF00, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h0000_FFFF, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hFFFF_0000, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h3333_3333, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hCCCC_CCCC, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'h0000_0000, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hFFFF_FFFF, 0, ST_OK, 32'h0, 0));
		dir_rows.push_back(make_row(OP_PUSH_FRONT, 32'hDEAD_BEEF, 1, ST_FULL, 32'h0, 16));
		dir_rows.push_back(make_row(OP_PUSH_REAR,  32'hCAFE_F00D, 1, ST_FULL, 32'h0, 16));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_beat(dir_rows[i]);

		// hold off until the output side has caught up
		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();

		mode_left = 0;
		mode      = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode_left  = $urandom_range(10, 60);
				mode       = $urandom_range(0, 2);
				send_quiet = ($urandom_range(0, 3) == 0);
			end
			mode_left--;
			r = $urandom_range(0, 99);
			// mode 0 fills, mode 1 drains, mode 2 stays balanced
			case (mode)
				0:       op = (r < 75) ? (r[0] ? OP_PUSH_FRONT : OP_PUSH_REAR)
					: (r[0] ? OP_POP_FRONT : OP_POP_REAR);
				1:       op = (r < 25) ? (r[0] ? OP_PUSH_FRONT : OP_PUSH_REAR)
					: (r[0] ? OP_POP_FRONT : OP_POP_REAR);
				default: op = op_t'($urandom_range(0, 3));
			endcase
			row = make_row(op, pick_value(), 0, ST_OK, 32'h0, 0);
			send_beat(row);
			if (n == RANDOM_ITEMS / 2) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				wait_drained();
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		$display("sent %0d beats, checked %0d results: %0d full, %0d empty, %0d nonzero pops",
			beats_sent, beats_checked, full_seen, empty_seen, pops_ok_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
